>>> rtl/msc_pkg.sv
// msc_pkg: shared constants, codes and types of the marquee scroll composer
// no dependencies; imported by every rtl module of the block

package msc_pkg;

   localparam int DISPLAY_COLUMNS = 32;
   localparam int TEXT_DEPTH      = 256;
   localparam int TIME_DEPTH      = 64;

   localparam int COL_W      = $clog2(DISPLAY_COLUMNS);
   localparam int POS_W      = $clog2(DISPLAY_COLUMNS + 1);
   localparam int TIM_ADDR_W = $clog2(TIME_DEPTH);
   localparam int TXT_ADDR_W = $clog2(TEXT_DEPTH);
   localparam int TIM_LEN_W  = $clog2(TIME_DEPTH + 1);
   localparam int TXT_LEN_W  = $clog2(TEXT_DEPTH + 1);
   localparam int SCR_W      = $clog2(TEXT_DEPTH + TIME_DEPTH + 1);
   localparam int CALC_W     = $clog2(TEXT_DEPTH + TIME_DEPTH + 2 * DISPLAY_COLUMNS + 512);

   localparam int PAUSE_W = 17;
   localparam logic [PAUSE_W-1:0] PAUSE_MAX = 17'h10000;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ALIGN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_TICKS   = 2'd3;

   localparam logic [1:0] DISP_TIME = 2'd0;
   localparam logic [1:0] DISP_TEXT = 2'd1;
   localparam logic [1:0] DISP_BOTH = 2'd2;
   localparam logic [1:0] DISP_OFF  = 2'd3;

   localparam logic [1:0] MODE_TIME = 2'd0;
   localparam logic [1:0] MODE_TEXT = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [7:0] DIVIDER_BITS = 8'hFF;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_TIME,
      SRC_DIV,
      SRC_TEXT
   } msc_src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EMIT
   } msc_state_type;

   typedef struct packed {
      logic write_time;
      logic write_text;
      logic tick;
      logic setup;
      logic issue;
   } msc_cmd_type;

   typedef struct packed {
      logic frame_due;
      logic col_last;
      logic advance;
   } msc_status_type;

endpackage

>>> rtl/msc_req_if.sv
// msc_req_if: input channel of the marquee scroll composer (valid/ready word)
// no dependencies

interface msc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] column_index;
   logic [7:0] column_bits;
   logic [8:0] content_length;
   logic       transition_busy;

   modport source (
      output valid, mode, column_index, column_bits, content_length, transition_busy,
      input  ready
   );

   modport sink (
      input  valid, mode, column_index, column_bits, content_length, transition_busy,
      output ready
   );
endinterface

>>> rtl/msc_rsp_if.sv
// msc_rsp_if: result channel of the marquee scroll composer (valid/ready word)
// no dependencies

interface msc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] out_column;
   logic [7:0] out_bits;
   logic       frame_last;
   logic       scroll_wrapped;

   modport source (
      output valid, out_column, out_bits, frame_last, scroll_wrapped,
      input  ready
   );

   modport sink (
      input  valid, out_column, out_bits, frame_last, scroll_wrapped,
      output ready
   );
endinterface

>>> rtl/msc_datapath.sv
// msc_datapath: csr registers, column stores, scroll engine, frame layout and
// the two-stage column output pipeline; depends on msc_pkg

module msc_datapath
   import msc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [7:0]            req_column_index,
   input  logic [7:0]            req_column_bits,
   input  logic [8:0]            req_content_length,
   input  logic                  req_transition_busy,
   input  msc_cmd_type           cmd,
   output msc_status_type        status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [5:0]            rsp_out_column,
   output logic [7:0]            rsp_out_bits,
   output logic                  rsp_frame_last,
   output logic                  rsp_scroll_wrapped
);

   // configuration
   logic [1:0]  disp_mode_ff;
   logic        center_ff;
   logic        scroll_en_ff;
   logic [15:0] delay_ff;

   // scroll state
   logic [TIM_LEN_W-1:0] time_len_ff, time_len_in;
   logic [TXT_LEN_W-1:0] text_len_ff, text_len_in;
   logic [SCR_W-1:0]     scroll_ff, scroll_in;
   logic [PAUSE_W-1:0]   pause_ff, pause_in;
   logic                 run_ff, run_in;
   logic                 wrap_ff, wrap_in;
   logic                 dirty_ff;
   logic                 tchg_ff;
   logic                 changed;
   logic                 should;
   logic                 end_hit;
   logic                 frame_due;

   // stores
   logic [7:0] time_mem [TIME_DEPTH];
   logic [7:0] text_mem [TEXT_DEPTH];
   logic [7:0] time_rd_ff;
   logic [7:0] text_rd_ff;

   // layout
   logic [POS_W-1:0] tstart_ff, tend_ff, div_pos_ff, xstart_ff;
   logic             time_en_ff, div_en_ff, text_en_ff;

   // column pipeline
   logic [COL_W-1:0] col_ff;
   logic             s1_valid_ff;
   msc_src_type      s1_src_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_last_ff;
   logic             s1_wrap_ff;
   logic             out_valid_ff;
   logic [5:0]       out_col_ff;
   logic [7:0]       out_bits_ff;
   logic             out_last_ff;
   logic             out_wrap_ff;

   logic [CALC_W-1:0] disp_w, tsz_w, xsz_w, teff_w, pnext_w, idx_w, len_w;
   logic [CALC_W-1:0] tclip_w, tstart_w, tend_w, pos_w, avail_w, xstart_w;
   logic [CALC_W-1:0] c_w, toff_w, k_w;
   logic              time_en, ctr_time, div_en, gap_en, text_en;
   logic              time_hit, text_hit;
   logic              advance;
   logic              col_last;
   msc_src_type       src;
   logic [7:0]        out_bits_in;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         disp_mode_ff <= DISP_TEXT;
         center_ff    <= 1'b0;
         scroll_en_ff <= 1'b1;
         delay_ff     <= 16'd60;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:  disp_mode_ff <= csr_data[1:0];
            CSR_CENTER_ALIGN:  center_ff    <= csr_data[0];
            CSR_SCROLL_ENABLE: scroll_en_ff <= csr_data[0];
            CSR_DELAY_TICKS:   delay_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- writes
   assign disp_w   = CALC_W'(DISPLAY_COLUMNS);
   assign idx_w    = CALC_W'(req_column_index);
   assign len_w    = CALC_W'(req_content_length);
   assign time_hit = idx_w < CALC_W'(TIME_DEPTH);
   assign text_hit = idx_w < CALC_W'(TEXT_DEPTH);

   assign time_len_in = (len_w > CALC_W'(TIME_DEPTH)) ? TIM_LEN_W'(TIME_DEPTH)
                                                       : TIM_LEN_W'(req_content_length);
   assign text_len_in = (len_w > CALC_W'(TEXT_DEPTH)) ? TXT_LEN_W'(TEXT_DEPTH)
                                                       : TXT_LEN_W'(req_content_length);

   // ---------------------------------------------------------------- scroll engine
   assign tsz_w   = CALC_W'(time_len_ff);
   assign xsz_w   = CALC_W'(text_len_ff);
   assign teff_w  = (disp_mode_ff == DISP_BOTH) ? tsz_w : '0;
   assign pnext_w = CALC_W'(scroll_ff) + CALC_W'(1);

   // negative text space in mode both is folded into the sums
   always_comb begin
      should  = 1'b0;
      end_hit = 1'b0;
      case (disp_mode_ff) inside
         DISP_TIME: begin
            should  = scroll_en_ff && (tsz_w > disp_w);
            end_hit = (pnext_w + disp_w) >= tsz_w;
         end
         DISP_TEXT, DISP_BOTH: begin
            should  = scroll_en_ff && ((xsz_w + teff_w) > disp_w);
            end_hit = (pnext_w + disp_w) >= (xsz_w + teff_w);
         end
         default: ;
      endcase
   end

   always_comb begin
      scroll_in = scroll_ff;
      pause_in  = pause_ff;
      run_in    = run_ff;
      wrap_in   = 1'b0;
      changed   = 1'b0;
      if (!run_ff && (pause_ff >= PAUSE_W'(delay_ff)) && !req_transition_busy) begin
         if (scroll_ff != '0) begin
            wrap_in   = 1'b1;
            pause_in  = PAUSE_W'(1);
            scroll_in = '0;
            changed   = 1'b1;
         end else begin
            run_in = 1'b1;
         end
      end else if (!run_ff) begin
         if (pause_ff != PAUSE_MAX) begin
            pause_in = pause_ff + PAUSE_W'(1);
         end
      end
      if (run_in) begin
         if (should) begin
            scroll_in = SCR_W'(pnext_w);
            changed   = 1'b1;
            if (end_hit) begin
               run_in   = 1'b0;
               pause_in = '0;
            end
         end else if (scroll_ff != '0) begin
            scroll_in = '0;
            changed   = 1'b1;
         end
      end
   end

   assign frame_due = changed || dirty_ff || tchg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_len_ff <= '0;
         text_len_ff <= '0;
         scroll_ff   <= '0;
         pause_ff    <= '0;
         run_ff      <= 1'b0;
         wrap_ff     <= 1'b0;
         dirty_ff    <= 1'b1;
         tchg_ff     <= 1'b0;
      end else begin
         if (cmd.write_time) begin
            time_len_ff <= time_len_in;
            tchg_ff     <= 1'b1;
         end
         if (cmd.write_text) begin
            text_len_ff <= text_len_in;
            scroll_ff   <= '0;
            pause_ff    <= '0;
            run_ff      <= 1'b0;
            dirty_ff    <= 1'b1;
         end
         if (cmd.tick) begin
            scroll_ff <= scroll_in;
            pause_ff  <= pause_in;
            run_ff    <= run_in;
            wrap_ff   <= wrap_in;
            tchg_ff   <= 1'b0;
            if (frame_due) begin
               dirty_ff <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- frame layout
   always_comb begin
      tclip_w  = (tsz_w > disp_w) ? disp_w : tsz_w;
      time_en  = (disp_mode_ff != DISP_TEXT) && (disp_mode_ff != DISP_OFF) && (tsz_w != '0);
      ctr_time = time_en && center_ff && (tsz_w <= disp_w) && (disp_mode_ff == DISP_TIME);
      tstart_w = ctr_time ? ((disp_w - tclip_w) >> 1) : '0;
      tend_w   = tstart_w + tclip_w;
      div_en   = time_en && !ctr_time && (disp_mode_ff == DISP_BOTH) && (tclip_w < disp_w);
      // one blank column after the divider only while the text sits at offset zero
      gap_en   = div_en && ((tclip_w + CALC_W'(1)) < disp_w) && (scroll_ff == '0);
      pos_w    = (time_en ? tclip_w : '0) + CALC_W'(div_en) + CALC_W'(gap_en);
      avail_w  = disp_w - pos_w;
      text_en  = ((disp_mode_ff == DISP_TEXT) || (disp_mode_ff == DISP_BOTH)) && (xsz_w != '0);
      xstart_w = (center_ff && (xsz_w < avail_w)) ? pos_w + ((avail_w - xsz_w) >> 1) : pos_w;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         tstart_ff  <= POS_W'(tstart_w);
         tend_ff    <= POS_W'(tend_w);
         div_pos_ff <= POS_W'(tclip_w);
         xstart_ff  <= POS_W'(xstart_w);
         time_en_ff <= time_en;
         div_en_ff  <= div_en;
         text_en_ff <= text_en;
      end
   end

   // ---------------------------------------------------------------- column issue
   assign advance  = !out_valid_ff || rsp_ready;
   assign col_last = col_ff == COL_W'(DISPLAY_COLUMNS - 1);
   assign c_w      = CALC_W'(col_ff);
   assign toff_w   = c_w - CALC_W'(tstart_ff);
   assign k_w      = CALC_W'(scroll_ff) + c_w - CALC_W'(xstart_ff);

   always_comb begin
      if (time_en_ff && (c_w >= CALC_W'(tstart_ff)) && (c_w < CALC_W'(tend_ff))) begin
         src = SRC_TIME;
      end else if (div_en_ff && (c_w == CALC_W'(div_pos_ff))) begin
         src = SRC_DIV;
      end else if (text_en_ff && (c_w >= CALC_W'(xstart_ff)) && (k_w < xsz_w)) begin
         src = SRC_TEXT;
      end else begin
         src = SRC_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else if (cmd.setup) begin
         col_ff <= '0;
      end else if (cmd.issue) begin
         col_ff <= col_ff + COL_W'(1);
      end
   end

   // stores: one write port, registered read that moves with the pipeline
   always_ff @(posedge clock) begin
      if (cmd.write_time && time_hit) begin
         time_mem[idx_w[TIM_ADDR_W-1:0]] <= req_column_bits;
      end
      if (advance) begin
         time_rd_ff <= time_mem[toff_w[TIM_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_text && text_hit) begin
         text_mem[idx_w[TXT_ADDR_W-1:0]] <= req_column_bits;
      end
      if (advance) begin
         text_rd_ff <= text_mem[k_w[TXT_ADDR_W-1:0]];
      end
   end

   // ---------------------------------------------------------------- output pipeline
   always_comb begin
      case (s1_src_ff)
         SRC_TIME: out_bits_in = time_rd_ff;
         SRC_DIV:  out_bits_in = DIVIDER_BITS;
         SRC_TEXT: out_bits_in = text_rd_ff;
         default:  out_bits_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_src_ff   <= src;
         s1_col_ff   <= col_ff;
         s1_last_ff  <= col_last;
         s1_wrap_ff  <= wrap_ff;
         out_col_ff  <= 6'(s1_col_ff);
         out_bits_ff <= out_bits_in;
         out_last_ff <= s1_last_ff;
         out_wrap_ff <= s1_wrap_ff;
      end
   end

   assign status.frame_due = frame_due;
   assign status.col_last  = col_last;
   assign status.advance   = advance;

   assign rsp_valid          = out_valid_ff;
   assign rsp_out_column     = out_col_ff;
   assign rsp_out_bits       = out_bits_ff;
   assign rsp_frame_last     = out_last_ff;
   assign rsp_scroll_wrapped = out_wrap_ff;

   // ---------------------------------------------------------------- checks
   a_text_restart: assert property (@(posedge clock) disable iff (reset)
      cmd.write_text |=> (scroll_ff == '0) && !run_ff && dirty_ff)
      else $error("text write did not restart scrolling");

   a_tick_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.tick |=> !tchg_ff && !dirty_ff)
      else $error("tick left a pending change flag");

   a_issue_room: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> advance)
      else $error("column issued into a stalled pipeline");

   a_wrap_home: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick && wrap_in) |=> (scroll_ff == '0) && wrap_ff && !run_ff)
      else $error("wrap did not return scroll to offset zero");

endmodule

>>> rtl/msc_controller.sv
// msc_controller: sequencer that takes words, starts store writes and ticks,
// and steps the frame layout and column issue; depends on msc_pkg

module msc_controller
   import msc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic [1:0]     req_mode,
   output logic           req_ready,
   input  msc_status_type status,
   output msc_cmd_type    cmd
);

   msc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_mode)
                  MODE_TIME: cmd.write_time = 1'b1;
                  MODE_TEXT: cmd.write_text = 1'b1;
                  MODE_TICK: begin
                     cmd.tick = 1'b1;
                     if (status.frame_due) begin
                        state_in = ST_SETUP;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.advance) begin
               cmd.issue = 1'b1;
               if (status.col_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> rtl/marquee_scroll_composer.sv
// marquee_scroll_composer: top level of the column marquee frame composer
// depends on msc_pkg, msc_req_if, msc_rsp_if, msc_controller, msc_datapath
//
//   channel   dir   word
//   req       in    mode, column_index, column_bits, content_length, transition_busy
//   rsp       out   out_column, out_bits, frame_last, scroll_wrapped
//   csr_*     in    write enable, register index, 16-bit write data
//
// column writes and ticks that change nothing leave the controller idle for the next word
// a tick that emits a frame holds req off through the setup state and the emit state,
// which runs the single column issue path with one store read per column
// first column goes via setup, s1 and out; reset is synchronous, stores are not cleared
// rsp stalls freeze column issue; a new word is taken while the last column still waits

module marquee_scroll_composer
   import msc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   msc_req_if.sink               req,
   msc_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   msc_cmd_type    cmd;
   msc_status_type status;

   msc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msc_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_column_index    (req.column_index),
      .req_column_bits     (req.column_bits),
      .req_content_length  (req.content_length),
      .req_transition_busy (req.transition_busy),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp.ready),
      .rsp_valid           (rsp.valid),
      .rsp_out_column      (rsp.out_column),
      .rsp_out_bits        (rsp.out_bits),
      .rsp_frame_last      (rsp.frame_last),
      .rsp_scroll_wrapped  (rsp.scroll_wrapped)
   );

endmodule

>>> test/marquee_scroll_composer_tb.sv
// marquee_scroll_composer_tb: self-checking bench for the column marquee composer
// drives column loads and frame ticks, predicts every emitted column word and compares
// depends on msc_pkg, msc_req_if, msc_rsp_if and the marquee_scroll_composer rtl

module marquee_scroll_composer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msc_pkg::*;

   localparam logic [1:0] MODE_IGNORED    = 2'd3;
   localparam int         DRAIN_CYCLES    = 40;
   localparam int         HOLD_OFF_CYCLES = 600;
   localparam int         RANDOM_WORDS    = 20;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] column_index;
      logic [7:0] column_bits;
      logic [8:0] content_length;
      logic       transition_busy;
   } req_word_type;

   typedef struct packed {
      logic [5:0] column;
      logic [7:0] bits;
      logic       last;
      logic       wrapped;
   } col_word_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   msc_req_if req ();
   msc_rsp_if rsp ();

   marquee_scroll_composer DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // marquee state as the block should hold it
   logic [7:0] time_cols [TIME_DEPTH];
   logic [7:0] text_cols [TEXT_DEPTH];
   int         time_len;
   int         text_len;
   int         scroll_ofs;
   int         pause_ticks;
   bit         redraw;
   bit         time_dirty;
   logic [1:0] cfg_disp;
   bit         cfg_center;
   bit         cfg_scroll;
   int         cfg_delay;

   col_word_type pending_columns [$];

   int errors;
   int words_sent;
   int columns_seen;
   int frames_due;
   int wrap_frames;
   int burst_left;
   bit gaps_on;
   int hold_left;
   bit hold_off_request;
   int stall_pct;
   int stall_tick;

   always #5 clock = ~clock;

   // applies one accepted word to the marquee state and queues the frame it causes
   function automatic void advance_marquee(req_word_type w);
      int           tsize;
      int           xsize;
      int           space;
      int           pos;
      int           off;
      int           i;
      int           k;
      bit           should;
      bit           changed;
      bit           wrapped;
      bit           at_end;
      bit           with_text;
      logic [7:0]   frame [DISPLAY_COLUMNS];
      col_word_type item;

      case (w.mode)
         MODE_TIME: begin
            if (w.column_index < TIME_DEPTH)
               time_cols[w.column_index] = w.column_bits;
            time_len   = (w.content_length > TIME_DEPTH) ? TIME_DEPTH : int'(w.content_length);
            time_dirty = 1'b1;
            return;
         end
         MODE_TEXT: begin
            text_cols[w.column_index] = w.column_bits;
            text_len    = (w.content_length > TEXT_DEPTH) ? TEXT_DEPTH : int'(w.content_length);
            scroll_ofs  = 0;
            pause_ticks = 0;
            redraw      = 1'b1;
            return;
         end
         MODE_IGNORED: return;
         default: ;
      endcase

      // frame tick: scroll engine
      tsize   = (cfg_disp == DISP_TIME || cfg_disp == DISP_BOTH) ? time_len : 0;
      xsize   = text_len;
      space   = 0;
      should  = 1'b0;
      changed = 1'b0;
      wrapped = 1'b0;
      if (cfg_disp == DISP_TIME) begin
         should = cfg_scroll && tsize > DISPLAY_COLUMNS;
      end else if (cfg_disp == DISP_TEXT || cfg_disp == DISP_BOTH) begin
         space  = (cfg_disp == DISP_TEXT) ? DISPLAY_COLUMNS : DISPLAY_COLUMNS - tsize;
         should = cfg_scroll && xsize > space;
      end

      if (pause_ticks >= 0 && pause_ticks >= cfg_delay && !w.transition_busy) begin
         if (scroll_ofs != 0) begin
            wrapped     = 1'b1;
            pause_ticks = 1;
            scroll_ofs  = 0;
            changed     = 1'b1;
         end else begin
            pause_ticks = -1;
         end
      end else if (pause_ticks >= 0) begin
         if (pause_ticks < 65536)
            pause_ticks++;
      end

      if (pause_ticks == -1) begin
         if (should) begin
            scroll_ofs++;
            changed = 1'b1;
            if (cfg_disp == DISP_TIME)
               at_end = scroll_ofs + DISPLAY_COLUMNS >= tsize;
            else
               at_end = scroll_ofs + space >= xsize;
            if (at_end)
               pause_ticks = 0;
         end else if (scroll_ofs != 0) begin
            scroll_ofs = 0;
            changed    = 1'b1;
         end
      end

      changed    = changed || redraw || time_dirty;
      time_dirty = 1'b0;
      if (!changed)
         return;
      redraw = 1'b0;

      // frame layout: time, divider and gap, then shifted text
      with_text = (cfg_disp == DISP_TEXT || cfg_disp == DISP_BOTH);
      foreach (frame[c])
         frame[c] = 8'h00;
      pos = 0;
      if (cfg_disp != DISP_OFF) begin
         if (cfg_disp != DISP_TEXT && time_len > 0) begin
            if (cfg_center && time_len <= DISPLAY_COLUMNS && !with_text) begin
               off = (DISPLAY_COLUMNS - time_len) / 2;
               for (i = 0; i < time_len; i++)
                  frame[off + i] = time_cols[i];
            end else begin
               for (pos = 0; pos < time_len && pos < DISPLAY_COLUMNS; pos++)
                  frame[pos] = time_cols[pos];
               if (cfg_disp == DISP_BOTH && pos < DISPLAY_COLUMNS) begin
                  frame[pos] = DIVIDER_BITS;
                  pos++;
                  if (pos < DISPLAY_COLUMNS && scroll_ofs == 0) begin
                     frame[pos] = 8'h00;
                     pos++;
                  end
               end
            end
         end
         if (with_text && text_len > 0) begin
            if (cfg_center && text_len < DISPLAY_COLUMNS - pos)
               pos += (DISPLAY_COLUMNS - pos - text_len) / 2;
            for (k = scroll_ofs; pos < DISPLAY_COLUMNS && k < text_len; k++) begin
               frame[pos] = text_cols[k];
               pos++;
            end
         end
      end

      frames_due++;
      if (wrapped)
         wrap_frames++;
      foreach (frame[c]) begin
         item = '{column: 6'(c), bits: frame[c],
                  last: (c == DISPLAY_COLUMNS - 1), wrapped: wrapped};
         pending_columns.insert(pending_columns.size(), item);
      end
   endfunction

   function automatic req_word_type tick_word(logic busy);
      return '{mode: MODE_TICK, column_index: 8'($urandom), column_bits: 8'($urandom),
               content_length: 9'($urandom_range(0, 256)), transition_busy: busy};
   endfunction

   function automatic req_word_type column_word(logic [1:0] mode, int idx, int bits, int len);
      return '{mode: mode, column_index: 8'(idx), column_bits: 8'(bits),
               content_length: 9'(len), transition_busy: 1'($urandom)};
   endfunction

   function automatic req_word_type noise_word();
      return '{mode: MODE_IGNORED, column_index: 8'($urandom), column_bits: 8'($urandom),
               content_length: 9'($urandom_range(0, 256)), transition_busy: 1'($urandom)};
   endfunction

   // offer one word, wait for it to be taken, then maybe pause between bursts
   task automatic send_word(input req_word_type w);
      req.valid           <= 1'b1;
      req.mode            <= w.mode;
      req.column_index    <= w.column_index;
      req.column_bits     <= w.column_bits;
      req.content_length  <= w.content_length;
      req.transition_busy <= w.transition_busy;
      @(posedge clock);
      while (!req.ready)
         @(posedge clock);
      advance_marquee(w);
      if (w.mode != MODE_IGNORED)
         words_sent++;
      if (gaps_on) begin
         burst_left--;
         if (burst_left <= 0) begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
               @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (pending_columns.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   // writes all four registers once the block is idle; junk above the used bits
   task automatic apply_settings(logic [1:0] disp, bit center, bit scroll, int delay);
      logic [CSR_IDX_W-1:0]  regs [4];
      logic [CSR_DATA_W-1:0] vals [4];
      int                    r;

      regs = '{CSR_DISPLAY_MODE, CSR_CENTER_ALIGN, CSR_SCROLL_ENABLE, CSR_DELAY_TICKS};
      vals[0] = (16'($urandom) & 16'hFFFC) | 16'(disp);
      vals[1] = (16'($urandom) & 16'hFFFE) | 16'(center);
      vals[2] = (16'($urandom) & 16'hFFFE) | 16'(scroll);
      vals[3] = 16'(delay);
      drain_results();
      for (r = 0; r < 4; r++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= regs[r];
         csr_data         <= vals[r];
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      cfg_disp   = disp;
      cfg_center = center;
      cfg_scroll = scroll;
      cfg_delay  = delay & 16'hFFFF;
   endtask

   task automatic report_mismatch(string field, int want, int got);
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   // result checker: every accepted column word against the oldest prediction
   always @(posedge clock) begin : check_columns
      col_word_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         columns_seen++;
         if (pending_columns.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected word, expected none, got column %0d bits %02h",
                     $time, rsp.out_column, rsp.out_bits);
         end else begin
            want = pending_columns.pop_front();
            if (rsp.out_column !== want.column)
               report_mismatch("out_column", want.column, rsp.out_column);
            if (rsp.out_bits !== want.bits)
               report_mismatch("out_bits", want.bits, rsp.out_bits);
            if (rsp.frame_last !== want.last)
               report_mismatch("frame_last", want.last, rsp.frame_last);
            if (rsp.scroll_wrapped !== want.wrapped)
               report_mismatch("scroll_wrapped", want.wrapped, rsp.scroll_wrapped);
         end
      end
   end

   // receiver: random stall density that changes during the run, plus hold-off
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_left        = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 300 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // blank frame after reset, then a tick with no change and an ignored word
   task automatic test_power_on();
      send_word(tick_word(1'b0));
      send_word(tick_word(1'b0));
      send_word(noise_word());
   endtask

   task automatic test_directed();
      apply_settings(DISP_TEXT, 1'b0, 1'b1, 0);
      send_word(column_word(MODE_TEXT, 0, 8'hFF, 1));
      send_word(column_word(MODE_TEXT, 1, 8'h00, 2));
      send_word(column_word(MODE_TEXT, 2, 8'hA5, 3));
      send_word(tick_word(1'b0));
      send_word(tick_word(1'b1));
      send_word(column_word(MODE_TIME, 0, 8'h3C, 1));
      send_word(column_word(MODE_TIME, 1, 8'h81, 2));
      // index past the time store only sets the length
      send_word(column_word(MODE_TIME, 255, 8'h77, 2));
      send_word(tick_word(1'b0));
      send_word(noise_word());

      apply_settings(DISP_BOTH, 1'b1, 1'b1, 0);
      send_word(column_word(MODE_TIME, 0, 8'hC3, 2));
      send_word(tick_word(1'b0));

      apply_settings(DISP_TIME, 1'b1, 1'b0, 65535);
      send_word(column_word(MODE_TIME, 1, 8'h18, 2));
      send_word(tick_word(1'b0));

      apply_settings(DISP_OFF, 1'b0, 1'b1, 1);
      send_word(column_word(MODE_TEXT, 2, 8'h5A, 3));
      send_word(tick_word(1'b0));

      apply_settings(DISP_BOTH, 1'b0, 1'b0, 0);
      send_word(column_word(MODE_TEXT, 0, 8'hE7, 3));
      send_word(tick_word(1'b1));
      send_word(column_word(MODE_TEXT, 1, 8'h42, 0));
      send_word(tick_word(1'b0));
   endtask

   // fill both stores front to back, then saturate lengths and scroll the full content
   task automatic test_fill_stores();
      int i;

      apply_settings(DISP_TEXT, 1'b0, 1'b1, 0);
      for (i = 0; i < TEXT_DEPTH; i++) begin
         send_word(column_word(MODE_TEXT, i, $urandom, i + 1));
         if (i % 32 == 31)
            send_word(tick_word(1'b0));
      end
      for (i = 0; i < TIME_DEPTH; i++) begin
         send_word(column_word(MODE_TIME, i, $urandom, i + 1));
         if (i % 16 == 15)
            send_word(tick_word(1'b0));
      end
      send_word(column_word(MODE_TIME, $urandom_range(TIME_DEPTH, 255), $urandom, 256));
      send_word(column_word(MODE_TEXT, $urandom_range(0, 255), $urandom,
                            $urandom_range(200, 256)));
      repeat (10)
         send_word(tick_word(1'b0));

      // time wider than the display scrolls the offset but never shifts time
      apply_settings(DISP_TIME, 1'b0, 1'b1, 2);
      repeat (40)
         send_word(tick_word(1'(($urandom_range(0, 7) == 0))));

      // time fills the display, text scrolls out of sight
      apply_settings(DISP_BOTH, 1'b1, 1'b1, 1);
      repeat (16)
         send_word(tick_word(1'b0));
   endtask

   // random messages: settings, a text load, optional time, then a run of ticks
   task automatic test_random_messages();
      int         start;
      int         msg_len;
      int         n;
      int         ticks;
      int         r;
      int         delay;
      logic [1:0] disp;

      start = words_sent;
      while (words_sent - start < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: disp = DISP_TEXT;
            4, 5, 6:    disp = DISP_BOTH;
            7, 8:       disp = DISP_TIME;
            default:    disp = DISP_OFF;
         endcase
         r = $urandom_range(0, 19);
         if (r == 0)
            delay = 65535;
         else if (r == 1)
            delay = $urandom_range(5, 65535);
         else
            delay = $urandom_range(0, 4);
         apply_settings(disp, 1'($urandom), ($urandom_range(0, 99) < 85), delay);
         gaps_on = ($urandom_range(0, 4) != 0);

         r = $urandom_range(0, 9);
         if (r < 7)
            msg_len = $urandom_range(1, 40);
         else if (r < 9)
            msg_len = $urandom_range(41, 120);
         else
            msg_len = $urandom_range(121, 256);
         n = $urandom_range(1, 6);
         repeat (n) begin
            n--;
            send_word(column_word(MODE_TEXT, $urandom_range(0, 255), $urandom,
                                  (n == 0) ? msg_len : $urandom_range(0, 256)));
         end
         if ($urandom_range(0, 1))
            send_word(column_word(MODE_TIME, $urandom_range(0, 255), $urandom,
                                  ($urandom_range(0, 9) < 8) ? $urandom_range(0, 30)
                                                             : $urandom_range(31, 256)));

         ticks = $urandom_range(4, 20) + ((msg_len < 60) ? msg_len : 60);
         repeat (ticks) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               send_word(column_word(MODE_TIME, $urandom_range(0, 255), $urandom,
                                     $urandom_range(0, 30)));
            else if (r < 10)
               send_word(noise_word());
            else if (r < 12)
               send_word(column_word(MODE_TEXT, $urandom_range(0, 255), $urandom,
                                     $urandom_range(0, 256)));
            else
               send_word(tick_word(1'(($urandom_range(0, 9) == 0))));
         end
      end
      gaps_on = 1'b1;
   endtask

   // receiver holds off while scrolling ticks keep coming, so the input backs up
   task automatic test_backpressure();
      apply_settings(DISP_TEXT, 1'b0, 1'b1, 0);
      gaps_on = 1'b0;
      send_word(column_word(MODE_TEXT, $urandom_range(0, 255), $urandom, 120));
      hold_off_request = 1'b1;
      repeat (24)
         send_word(tick_word(1'b0));
      drain_results();
      gaps_on = 1'b1;
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req.valid            = 1'b0;
      req.mode             = MODE_TICK;
      req.column_index     = '0;
      req.column_bits      = '0;
      req.content_length   = '0;
      req.transition_busy  = 1'b0;
      rsp.ready            = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_DISPLAY_MODE;
      csr_data             = '0;
      time_len             = 0;
      text_len             = 0;
      scroll_ofs           = 0;
      pause_ticks          = 0;
      redraw               = 1'b1;
      time_dirty           = 1'b0;
      cfg_disp             = DISP_TEXT;
      cfg_center           = 1'b0;
      cfg_scroll           = 1'b1;
      cfg_delay            = 60;
      errors               = 0;
      words_sent           = 0;
      columns_seen         = 0;
      frames_due           = 0;
      wrap_frames          = 0;
      burst_left           = 4;
      gaps_on              = 1'b1;
      hold_left            = 0;
      hold_off_request     = 1'b0;
      stall_pct            = 0;
      stall_tick           = 0;

      repeat (8)
         @(posedge clock);
      reset <= 1'b0;

      test_power_on();
      test_directed();
      test_fill_stores();
      test_random_messages();
      test_backpressure();
      drain_results();

      $display("run covered %0d column and tick words in all display modes and settings",
               words_sent);
      $display("%0d frames predicted (%0d after a scroll wrap), %0d column words checked",
               frames_due, wrap_frames, columns_seen);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d column words still outstanding", pending_columns.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> marquee_scroll_composer.f
rtl/msc_pkg.sv
rtl/msc_req_if.sv
rtl/msc_rsp_if.sv
rtl/msc_datapath.sv
rtl/msc_controller.sv
rtl/marquee_scroll_composer.sv
test/marquee_scroll_composer_tb.sv
